// ===== rtl/core/pixel_brightness_contrast_gamma_macros.svh =====
// ----------------------------------------------------------------------------
// pixel_brightness_contrast_gamma_macros
// assertion macros used by the top block to check itself
// ----------------------------------------------------------------------------
`ifndef PIXEL_BRIGHTNESS_CONTRAST_GAMMA_MACROS_SVH
`define PIXEL_BRIGHTNESS_CONTRAST_GAMMA_MACROS_SVH

// same-cycle implication
`define PBCG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBCG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pbcg_pkg.sv =====
// ----------------------------------------------------------------------------
// pbcg_pkg
// shared constants and types of the brightness / contrast / gamma block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbcg_pkg;

  localparam int PIX_W       = 8;
  localparam int NUM_CHANS   = 3;
  localparam int LANES       = 3;
  localparam int TABLE_DEPTH = 256;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

  localparam int GAIN_W = 12;
  localparam int OFFS_W = 9;
  localparam int PROD_W = GAIN_W + PIX_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int QR_W   = SUM_W - PIX_W + 1;

  localparam int IN_DATA_W  = 5 * PIX_W;
  localparam int OUT_DATA_W = NUM_CHANS * PIX_W;

  // output queue and credit limit on pixels in flight
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int CREDITS   = 5;
  localparam int CREDIT_W  = $clog2(CREDITS + 1);

  localparam logic OP_PIXEL    = 1'b0;
  localparam logic OP_TABLE_WR = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = GAIN_W;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA_EN = 2'd2;

  typedef struct packed {
    logic                wr_en;
    logic [TABLE_AW-1:0] idx;
    logic [PIX_W-1:0]    val;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/pbcg_lane.sv =====
// ----------------------------------------------------------------------------
// pbcg_lane
// one channel: scale, offset, round half to even, clamp, gamma lookup
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbcg_lane (
  input  wire logic                                clk,
  input  wire logic [pbcg_pkg::PIX_W-1:0]          x,
  input  wire logic [pbcg_pkg::GAIN_W-1:0]         gain,
  input  wire logic signed [pbcg_pkg::OFFS_W-1:0]  offset,
  input  wire logic                                gamma_en,
  input  wire pbcg_pkg::lane_ctrl_t                ctrl,
  output logic [pbcg_pkg::PIX_W-1:0]               y
);

  logic [pbcg_pkg::PROD_W-1:0]   prod;
  logic [pbcg_pkg::OFFS_W-1:0]   off_biased;
  logic [pbcg_pkg::SUM_W-1:0]    sum;
  logic [pbcg_pkg::QR_W-1:0]     q_rnd;
  logic                          round_up;
  logic [pbcg_pkg::PIX_W-1:0]    clamped_next;
  logic [pbcg_pkg::PIX_W-1:0]    clamped;
  logic [pbcg_pkg::PIX_W-1:0]    lut_q;
  logic [pbcg_pkg::PIX_W-1:0]    byp_q;
  logic [pbcg_pkg::PIX_W-1:0]    gamma_mem [pbcg_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    prod <= pbcg_pkg::PROD_W'(gain) * pbcg_pkg::PROD_W'(x);
  end

  // offset + 256 keeps the sum non-negative: flip the sign bit
  assign off_biased = {~offset[pbcg_pkg::OFFS_W-1], offset[pbcg_pkg::OFFS_W-2:0]};
  assign sum = {1'b0, prod} + pbcg_pkg::SUM_W'({off_biased, 8'h00});
  assign round_up = sum[7] & ((|sum[6:0]) | sum[8]);
  assign q_rnd = {1'b0, sum[pbcg_pkg::SUM_W-1:8]} + pbcg_pkg::QR_W'(round_up);

  // biased result: below 256 is negative, above 511 overflows
  always_comb begin
    if (q_rnd < pbcg_pkg::QR_W'(256)) begin
      clamped_next = '0;
    end else if (q_rnd > pbcg_pkg::QR_W'(511)) begin
      clamped_next = '1;
    end else begin
      clamped_next = q_rnd[pbcg_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    clamped <= clamped_next;
  end

  // table write and pixel read meet here in item order
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      gamma_mem[ctrl.idx] <= ctrl.val;
    end
    lut_q <= gamma_mem[clamped];
    byp_q <= clamped;
  end

  assign y = gamma_en ? lut_q : byp_q;

endmodule

`default_nettype wire

// ===== rtl/core/pbcg_merge.sv =====
// ----------------------------------------------------------------------------
// pbcg_merge
// joins lane results into one output item and queues it for the master side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbcg_merge (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 pix_accept,
  input  wire logic                                 push,
  input  wire logic [pbcg_pkg::OUT_DATA_W-1:0]      push_data,
  output logic                                      room,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [pbcg_pkg::OUT_DATA_W-1:0]           m_tdata
);

  logic [pbcg_pkg::OUT_DATA_W-1:0] queue [pbcg_pkg::OUT_DEPTH];
  logic [pbcg_pkg::OUT_PTR_W-1:0]  wr_ptr;
  logic [pbcg_pkg::OUT_PTR_W-1:0]  rd_ptr;
  logic [pbcg_pkg::OUT_PTR_W:0]    level;
  logic [pbcg_pkg::CREDIT_W-1:0]   occ;
  logic                            pop;

  assign m_tvalid = (level != '0);
  assign m_tdata  = queue[rd_ptr];
  assign pop      = m_tvalid & m_tready;
  assign room     = (occ < pbcg_pkg::CREDIT_W'(pbcg_pkg::CREDITS));

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
      occ    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + (pbcg_pkg::OUT_PTR_W+1)'(push) - (pbcg_pkg::OUT_PTR_W+1)'(pop);
      // pixels accepted and not yet handed off
      occ <= occ + pbcg_pkg::CREDIT_W'(pix_accept) - pbcg_pkg::CREDIT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pixel_brightness_contrast_gamma.sv =====
// ----------------------------------------------------------------------------
// pixel_brightness_contrast_gamma
// brightness / contrast / gamma point operation on up to three 8-bit channels
// ----------------------------------------------------------------------------
// Takes one item per clock while s_tready is high. Each channel runs in its own lane: a Q4.8 gain
// multiply, an offset add with round half to even and a clamp to 0..255,
// then an optional lookup in that lane's own 256-entry gamma table copy (one
// write port, one read port). A result passes the product, clamp and
// table-read registers, then is pushed into the output queue and leaves
// on a master-side handshake. Table-write items (tuser = 1) travel
// the same pipeline so they land in order with pixels, and give no result.
// Up to five pixels may be in flight; s_tready drops when that many wait.
// Gamma entries must be written before a pixel reads them.
`timescale 1ns / 1ps
`default_nettype none

`include "pixel_brightness_contrast_gamma_macros.svh"

module pixel_brightness_contrast_gamma (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // slave side
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // chan_a, chan_b, chan_c, entry_index, entry_value
  input  wire logic [pbcg_pkg::IN_DATA_W-1:0]       s_tdata,
  // operation
  input  wire logic                                 s_tuser,
  // master side
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // out_a, out_b, out_c
  output logic [pbcg_pkg::OUT_DATA_W-1:0]           m_tdata,
  // configuration
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [pbcg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pbcg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [pbcg_pkg::GAIN_W-1:0]        contrast_gain;
  logic signed [pbcg_pkg::OFFS_W-1:0] brightness_offset;
  logic                               gamma_enable;

  logic in_xfer;
  logic pix_accept;
  logic wr_accept;

  logic                          pix_v1;
  logic                          pix_v2;
  logic                          pix_v3;
  logic                          wr_v1;
  logic                          wr_v2;
  logic [pbcg_pkg::TABLE_AW-1:0] idx1;
  logic [pbcg_pkg::TABLE_AW-1:0] idx2;
  logic [pbcg_pkg::PIX_W-1:0]    val1;
  logic [pbcg_pkg::PIX_W-1:0]    val2;

  pbcg_pkg::lane_ctrl_t            lane_ctrl;
  logic [pbcg_pkg::OUT_DATA_W-1:0] lane_out;
  logic                            room;

  assign cfg_ready  = 1'b1;
  assign s_tready   = room;
  assign in_xfer    = s_tvalid & s_tready;
  assign pix_accept = in_xfer & (s_tuser == pbcg_pkg::OP_PIXEL);
  assign wr_accept  = in_xfer & (s_tuser == pbcg_pkg::OP_TABLE_WR);

  always_ff @(posedge clk) begin
    if (rst) begin
      contrast_gain     <= pbcg_pkg::GAIN_W'(256);
      brightness_offset <= '0;
      gamma_enable      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pbcg_pkg::REG_GAIN:     contrast_gain     <= cfg_data[pbcg_pkg::GAIN_W-1:0];
        pbcg_pkg::REG_OFFSET:   brightness_offset <= signed'(cfg_data[pbcg_pkg::OFFS_W-1:0]);
        pbcg_pkg::REG_GAMMA_EN: gamma_enable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_v1 <= 1'b0;
      pix_v2 <= 1'b0;
      pix_v3 <= 1'b0;
      wr_v1  <= 1'b0;
      wr_v2  <= 1'b0;
    end else begin
      pix_v1 <= pix_accept;
      pix_v2 <= pix_v1;
      pix_v3 <= pix_v2;
      wr_v1  <= wr_accept;
      wr_v2  <= wr_v1;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= s_tdata[4*pbcg_pkg::PIX_W-1 -: pbcg_pkg::TABLE_AW];
    val1 <= s_tdata[5*pbcg_pkg::PIX_W-1 -: pbcg_pkg::PIX_W];
    idx2 <= idx1;
    val2 <= val1;
  end

  assign lane_ctrl.wr_en = wr_v2;
  assign lane_ctrl.idx   = idx2;
  assign lane_ctrl.val   = val2;

  for (genvar i = 0; i < pbcg_pkg::NUM_CHANS; i++) begin : g_lane
    if (i < pbcg_pkg::LANES) begin : g_on
      pbcg_lane u_lane (
        .clk      (clk),
        .x        (s_tdata[i*pbcg_pkg::PIX_W +: pbcg_pkg::PIX_W]),
        .gain     (contrast_gain),
        .offset   (brightness_offset),
        .gamma_en (gamma_enable),
        .ctrl     (lane_ctrl),
        .y        (lane_out[i*pbcg_pkg::PIX_W +: pbcg_pkg::PIX_W])
      );
    end else begin : g_off
      assign lane_out[i*pbcg_pkg::PIX_W +: pbcg_pkg::PIX_W] = '0;
    end
  end

  pbcg_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .pix_accept (pix_accept),
    .push       (pix_v3),
    .push_data  (lane_out),
    .room       (room),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  `PBCG_ASSERT_NXT(a_pix_enters, clk, rst, pix_accept, pix_v1 && !wr_v1, "pixel transfer lost in pipeline")
  `PBCG_ASSERT_NXT(a_wr_enters, clk, rst, wr_accept, wr_v1 && !pix_v1, "table write lost in pipeline")
  `PBCG_ASSERT_IMP(a_stall_has_work, clk, rst, !s_tready, m_tvalid, "input stalled with no result queued")

endmodule

`default_nettype wire

// ===== test/tb_pixel_brightness_contrast_gamma.sv =====
// ----------------------------------------------------------------------------
// tb_pixel_brightness_contrast_gamma
// self-checking bench for the brightness / contrast / gamma pixel block
// ----------------------------------------------------------------------------
// Drives pixel and gamma-table-write items on the input stream and register
// writes on the config channel. An in-bench predictor keeps its own copy of
// the registers and the gamma table and works out each pixel's result when
// its transfer is accepted. The output stream is checked field by field
// against the oldest pending result. Both streams see random gaps and stalls.
`timescale 1ns / 1ps

module tb_pixel_brightness_contrast_gamma;
  import pbcg_pkg::*;

  // index with no register behind it, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] a;
  } pix_out_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tuser   = OP_PIXEL;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_GAIN;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor state
  logic [GAIN_W-1:0] gain_q   = 12'd256;
  int                offs_q   = 0;
  bit                gamma_on = 1'b0;
  logic [PIX_W-1:0]  gamma_lut [TABLE_DEPTH];

  pix_out_t pending_pixels [$];
  int       mismatch_count = 0;
  bit       burst_mode     = 1'b0;

  pixel_brightness_contrast_gamma dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [PIX_W-1:0] adjust_level(input logic [PIX_W-1:0] x);
    int t;
    int q;
    int r;
    t = int'(gain_q) * int'(x) + offs_q * 256;
    q = t >>> 8;
    r = t & 255;
    // round half to even
    if (r > 128 || (r == 128 && (q & 1) != 0)) q++;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    if (gamma_on) return gamma_lut[q];
    return q[PIX_W-1:0];
  endfunction

  function automatic pix_out_t predict_pixel(input logic [IN_DATA_W-1:0] data);
    logic [OUT_DATA_W-1:0] levels;
    levels = '0;
    for (int i = 0; i < NUM_CHANS; i++) begin
      if (i < LANES) levels[i*PIX_W +: PIX_W] = adjust_level(data[i*PIX_W +: PIX_W]);
    end
    return pix_out_t'(levels);
  endfunction

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_GAIN:     gain_q   = data;
      REG_OFFSET:   offs_q   = $signed(data[OFFS_W-1:0]);
      REG_GAMMA_EN: gamma_on = data[0];
      default: ;
    endcase
  endtask

  task automatic track_item(input logic op, input logic [IN_DATA_W-1:0] data);
    if (op == OP_TABLE_WR) begin
      gamma_lut[data[4*PIX_W-1:3*PIX_W]] = data[5*PIX_W-1:4*PIX_W];
    end else begin
      pending_pixels.push_back(predict_pixel(data));
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    pix_out_t got;
    pix_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = pix_out_t'(m_tdata);
      if (pending_pixels.size() == 0) begin
        report_mismatch("result with nothing pending", int'(m_tdata), 0);
      end else begin
        want = pending_pixels.pop_front();
        if (got.a !== want.a) report_mismatch("out_a", got.a, want.a);
        if (got.b !== want.b) report_mismatch("out_b", got.b, want.b);
        if (got.c !== want.c) report_mismatch("out_c", got.c, want.c);
      end
    end
  end

  // ---------------------------------------------------------------- output stalls

  initial begin : drive_m_tready
    int run;
    @(posedge clk);
    forever begin
      if (burst_mode || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        run = $urandom_range(1, 20);
      end else begin
        m_tready <= 1'b0;
        run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      repeat (run) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [PIX_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic op, input logic [IN_DATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    track_item(op, data);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                            input logic [PIX_W-1:0] c);
    // entry fields carry junk on pixels
    send_item(OP_PIXEL, {8'($urandom), 8'($urandom), c, b, a});
  endtask

  task automatic send_table_write(input logic [PIX_W-1:0] idx, input logic [PIX_W-1:0] val);
    send_item(OP_TABLE_WR, {val, idx, 8'($urandom), 8'($urandom), 8'($urandom)});
  endtask

  // config writes only happen with the block idle
  task automatic write_regs(input logic [GAIN_W-1:0] gain, input int offs, input bit gen,
                            input bit poke_spare);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] dat [4];
    logic [31:0]           junk;
    logic [OFFS_W-1:0]     offs9;
    int                    first;
    junk   = $urandom;
    offs9  = offs[OFFS_W-1:0];
    idx[0] = REG_SPARE;    dat[0] = junk[CFG_DATA_W-1:0];
    idx[1] = REG_GAIN;     dat[1] = gain;
    idx[2] = REG_OFFSET;   dat[2] = {junk[14:12], offs9};
    idx[3] = REG_GAMMA_EN; dat[3] = {junk[26:16], gen};
    first  = poke_spare ? 0 : 1;
    for (int k = first; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= dat[k];
      do @(posedge clk); while (!cfg_ready);
      apply_reg(idx[k], dat[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // table writes give no result, so let the pipeline drain past the last one
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_pixel(8'd0, 8'd255, 8'd128);
    send_pixel(8'd1, 8'd127, 8'd254);
  endtask

  task automatic test_gain_offset_rounding();
    wait_idle();
    write_regs(12'd4095, 255, 1'b0, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd1);
    wait_idle();
    write_regs(12'd0, -256, 1'b0, 1'b0);
    send_pixel(8'd255, 8'd128, 8'd0);
    wait_idle();
    // gain of one half puts every odd input on a tie
    write_regs(12'd128, 0, 1'b0, 1'b0);
    send_pixel(8'd1, 8'd3, 8'd5);
    send_pixel(8'd255, 8'd254, 8'd2);
    wait_idle();
    write_regs(12'd129, -1, 1'b0, 1'b0);
    send_pixel(8'd1, 8'd2, 8'd255);
    wait_idle();
    write_regs(12'd4095, -256, 1'b0, 1'b1);
    send_pixel(8'd0, 8'd64, 8'd255);
  endtask

  task automatic test_gamma_lookup();
    wait_idle();
    write_regs(12'd256, 0, 1'b0, 1'b0);
    send_table_write(8'd0, 8'hA5);
    send_table_write(8'd255, 8'h3C);
    send_table_write(8'd128, 8'h81);
    send_table_write(8'd77, 8'h00);
    wait_idle();
    write_regs(12'd256, 0, 1'b1, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd128);
    send_pixel(8'd77, 8'd128, 8'd0);
    // rewrite right ahead of a pixel that reads the same entry
    send_table_write(8'd77, 8'hFF);
    send_pixel(8'd77, 8'd77, 8'd0);
    wait_idle();
    write_regs(12'd4095, 255, 1'b1, 1'b0);
    send_pixel(8'd255, 8'd17, 8'd0);
    wait_idle();
    write_regs(12'd0, -256, 1'b1, 1'b0);
    send_pixel(8'd255, 8'd128, 8'd0);
  endtask

  task automatic test_table_fill();
    wait_idle();
    for (int i = 0; i < TABLE_DEPTH; i++) send_table_write(8'(i), 8'($urandom));
  endtask

  task automatic test_random_phases();
    logic [GAIN_W-1:0] gain;
    int                offs;
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 5))
        0:       gain = 12'd0;
        1:       gain = 12'd4095;
        2:       gain = 12'd256;
        3:       gain = 12'($urandom_range(0, 511));
        default: gain = 12'($urandom_range(0, 4095));
      endcase
      case ($urandom_range(0, 4))
        0:       offs = -256;
        1:       offs = 255;
        2:       offs = 0;
        3:       offs = $urandom_range(0, 40) - 20;
        default: offs = $urandom_range(0, 511) - 256;
      endcase
      wait_idle();
      write_regs(gain, offs, bit'(p % 2) ^ bit'($urandom_range(0, 1)),
                 $urandom_range(0, 3) == 0);
      for (int n = 0; n < 240; n++) begin
        if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 15) send_table_write(8'($urandom), 8'($urandom));
        else send_pixel(pick_level(), pick_level(), pick_level());
      end
      burst_mode = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_gain_offset_rounding();
    test_gamma_lookup();
    test_table_fill();
    test_random_phases();
    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
